FILE: src/pal_pkg.sv
`timescale 1ns / 1ps
package pal_pkg;

  localparam int CAPACITY = 64;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = 7;
  localparam int VW = 32;
  localparam int KW = 2;
  localparam int XW = ((CW > PW) ? CW : PW) + 1;

  localparam logic [KW-1:0] REQ_INSERT = 2'd0;
  localparam logic [KW-1:0] REQ_DELETE = 2'd1;
  localparam logic [KW-1:0] REQ_LOCATE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_SHIFT,
    ST_INS_PUT,
    ST_DEL_SHIFT,
    ST_LOC_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic          ok;
    logic [VW-1:0] removed_value;
    logic [PW-1:0] found_position;
    logic [PW-1:0] count;
  } res_t;

endpackage

FILE: src/positional_array_list.sv
`timescale 1ns / 1ps
// channel  | fields (tuser ; tdata, lowest bit first)
// s_*      | req_type[1:0] ; position[6:0], value[38:7]
// m_*      | ok[0] ; removed_value[31:0], found_position[38:32], count[45:39]
//
// one request at a time; s_tready is high only while the sequencer is idle
// insert and delete shift the elements one at a time, and locate reads them in order
// until a match, through the one read and one write port of the element ram; a rejected
// or unused request goes straight to its result, and any result can be held by m_tready
// rst is synchronous and clears the count, the read-valid flag and the handshake state only
// a finished result waits in the sequencer while the output register holds a transfer
module positional_array_list (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // position, value
  input  logic [1:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // removed_value, found_position, count
  output logic [0:0]  m_tuser    // ok
);
  import pal_pkg::*;

  res_t          res, out_q;
  logic          res_valid, res_ready;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [VW-1:0] rd_data, wr_data;

  assign res_ready = !m_tvalid || m_tready;

  pal_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req_type  (s_tuser),
    .position  (s_tdata[PW-1:0]),
    .value     (s_tdata[PW+VW-1:PW]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  pal_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (VW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_tuser = out_q.ok;
  assign m_tdata = {2'b00, out_q.count, out_q.found_position, out_q.removed_value};

endmodule

FILE: src/pal_ram.sv
`timescale 1ns / 1ps
module pal_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int ABITS = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [ABITS-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [ABITS-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/pal_seq.sv
`timescale 1ns / 1ps
module pal_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  logic [pal_pkg::KW-1:0]     req_type,
  input  logic [pal_pkg::PW-1:0]     position,
  input  logic signed [pal_pkg::VW-1:0] value,
  output logic                       res_valid,
  input  logic                       res_ready,
  output pal_pkg::res_t              res,
  output logic                       rd_en,
  output logic [pal_pkg::AW-1:0]     rd_addr,
  input  logic [pal_pkg::VW-1:0]     rd_data,
  output logic                       wr_en,
  output logic [pal_pkg::AW-1:0]     wr_addr,
  output logic [pal_pkg::VW-1:0]     wr_data
);
  import pal_pkg::*;

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [AW-1:0] ptr, ptr_next;
  logic [AW-1:0] pos_q, pos_q_next;
  logic [VW-1:0] val_q, val_q_next;
  logic          rvld;
  logic [AW-1:0] raddr_q;
  logic          ok_q, ok_q_next;
  logic [VW-1:0] removed_q, removed_q_next;
  logic [PW-1:0] found_q, found_q_next;

  logic [XW-1:0] pos_x, n_x;
  logic          ins_ok, del_ok, scanning;

  assign pos_x  = XW'(position);
  assign n_x    = XW'(count);
  assign ins_ok = (pos_x != '0) && (pos_x <= n_x + XW'(1)) && (n_x < XW'(CAPACITY));
  assign del_ok = (pos_x != '0) && (pos_x <= n_x);

  assign req_ready = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign res.ok             = ok_q;
  assign res.removed_value  = removed_q;
  assign res.found_position = found_q;
  assign res.count          = PW'(count);

  assign scanning = (state == ST_INS_SHIFT) || (state == ST_DEL_SHIFT) ||
                    (state == ST_LOC_SCAN);
  assign rd_addr  = ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      rvld  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rvld  <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    cnt       <= cnt_next;
    ptr       <= ptr_next;
    pos_q     <= pos_q_next;
    val_q     <= val_q_next;
    raddr_q   <= ptr;
    ok_q      <= ok_q_next;
    removed_q <= removed_q_next;
    found_q   <= found_q_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    cnt_next       = cnt;
    ptr_next       = ptr;
    pos_q_next     = pos_q;
    val_q_next     = val_q;
    ok_q_next      = ok_q;
    removed_q_next = removed_q;
    found_q_next   = found_q;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = raddr_q;
    wr_data        = rd_data;

    if (scanning && cnt != '0) begin
      rd_en    = 1'b1;
      cnt_next = cnt - CW'(1);
      ptr_next = (state == ST_INS_SHIFT) ? ptr - AW'(1) : ptr + AW'(1);
    end

    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          ok_q_next      = 1'b0;
          removed_q_next = '0;
          found_q_next   = '0;
          val_q_next     = value;
          pos_q_next     = AW'(pos_x - XW'(1));
          state_next     = ST_DONE;
          if (req_type == REQ_INSERT && ins_ok) begin
            cnt_next   = CW'(n_x - pos_x + XW'(1));
            ptr_next   = AW'(n_x - XW'(1));
            state_next = ST_INS_SHIFT;
          end else if (req_type == REQ_DELETE && del_ok) begin
            cnt_next   = CW'(n_x - pos_x + XW'(1));
            ptr_next   = AW'(pos_x - XW'(1));
            state_next = ST_DEL_SHIFT;
          end else if (req_type == REQ_LOCATE) begin
            cnt_next   = count;
            ptr_next   = '0;
            state_next = ST_LOC_SCAN;
          end
        end
      end
      ST_INS_SHIFT: begin
        if (rvld) begin
          wr_en   = 1'b1;
          wr_addr = raddr_q + AW'(1);
        end else if (cnt == '0) begin
          state_next = ST_INS_PUT;
        end
      end
      ST_INS_PUT: begin
        wr_en      = 1'b1;
        wr_addr    = pos_q;
        wr_data    = val_q;
        count_next = count + CW'(1);
        ok_q_next  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DEL_SHIFT: begin
        if (rvld) begin
          if (raddr_q == pos_q) begin
            removed_q_next = rd_data;
          end else begin
            wr_en   = 1'b1;
            wr_addr = raddr_q - AW'(1);
          end
        end else if (cnt == '0) begin
          count_next = count - CW'(1);
          ok_q_next  = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_LOC_SCAN: begin
        if (rvld && rd_data == val_q) begin
          rd_en        = 1'b0;
          ok_q_next    = 1'b1;
          found_q_next = PW'(XW'(raddr_q) + XW'(1));
          state_next   = ST_DONE;
        end else if (!rvld && cnt == '0) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
